>>> rtl/lmsrt_pkg.sv
// Shared types and constants for the LED matrix shift/rotate/trim block.
// Holds field widths, command and status codes and the cell control word.
// No dependencies.
`default_nettype none

package lmsrt_pkg;

    localparam int OP_W  = 4;
    localparam int COL_W = 6;
    localparam int ROW_W = 5;
    localparam int PIX_W = 8;
    localparam int SZW_W = 7;
    localparam int SZH_W = 6;
    localparam int WO_W  = 7;
    localparam int HO_W  = 6;
    localparam int ST_W  = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 32;
    localparam int DEF_PIXEL_BITS = 8;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 4'd0,
        OP_READ      = 4'd1,
        OP_SHIFT_L   = 4'd2,
        OP_SHIFT_R   = 4'd3,
        OP_SHIFT_U   = 4'd4,
        OP_SHIFT_D   = 4'd5,
        OP_ROT_L     = 4'd6,
        OP_ROT_R     = 4'd7,
        OP_TRIM_L    = 4'd8,
        OP_TRIM_R    = 4'd9,
        OP_TRIM_T    = 4'd10,
        OP_TRIM_B    = 4'd11,
        OP_SET_SIZE  = 4'd12
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOSIZE = 2'd1,
        ST_RANGE  = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_WRITE,
        CELL_SHL,
        CELL_SHR,
        CELL_SHU,
        CELL_SHD,
        CELL_LOAD
    } cell_op_t;

    // Per-row control word handed from the sequencer to one row cell.
    typedef struct packed {
        cell_op_t op;
        logic     live;
        logic     pix_we;
        logic     scr_we;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/lmsrt_cell.sv
// One row cell of the pixel matrix: a full row of pixels plus a scratch row.
// Trades rows with its upper and lower neighbors. Depends on lmsrt_pkg.
`default_nettype none

module lmsrt_cell #(
    parameter int MAX_WIDTH  = lmsrt_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = lmsrt_pkg::DEF_PIXEL_BITS,
    parameter int SCR_W      = lmsrt_pkg::DEF_MAX_HEIGHT
) (
    input  wire                                         aclk,
    input  lmsrt_pkg::cell_ctl_t                        ctl,
    input  wire [$clog2(MAX_WIDTH)-1:0]                 sel_col,
    input  wire [PIXEL_BITS-1:0]                        wr_pix,
    input  wire [$clog2(MAX_WIDTH+1)-1:0]               width,
    input  wire [MAX_WIDTH-1:0][PIXEL_BITS-1:0]         below_row,
    input  wire [MAX_WIDTH-1:0][PIXEL_BITS-1:0]         above_row,
    input  wire [SCR_W-1:0][PIXEL_BITS-1:0]             scr_bus,
    output logic [MAX_WIDTH-1:0][PIXEL_BITS-1:0]        row_out,
    output logic [PIXEL_BITS-1:0]                       sel_pix,
    output logic                                        row_nz
);
    import lmsrt_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [MAX_WIDTH-1:0][PIXEL_BITS-1:0] main_reg, main_next;
    logic [SCR_W-1:0][PIXEL_BITS-1:0]     scr_reg;

    always_comb begin
        main_next = main_reg;
        unique case (ctl.op)
            CELL_HOLD:  main_next = main_reg;
            CELL_CLEAR: main_next = '0;
            CELL_WRITE: begin
                if (ctl.pix_we) begin
                    main_next[sel_col] = wr_pix;
                end
            end
            CELL_SHL: begin
                for (int x = 0; x < MAX_WIDTH; x++) begin
                    main_next[x] = (x < MAX_WIDTH - 1) ? main_reg[(x + 1) % MAX_WIDTH] : '0;
                end
            end
            CELL_SHR: begin
                // The pixel pushed past the current width must not survive.
                for (int x = 0; x < MAX_WIDTH; x++) begin
                    main_next[x] = (x > 0 && WW'(x) < width) ?
                                   main_reg[(x + MAX_WIDTH - 1) % MAX_WIDTH] : '0;
                end
            end
            CELL_SHU: main_next = below_row;
            CELL_SHD: main_next = ctl.live ? above_row : '0;
            CELL_LOAD: begin
                for (int x = 0; x < MAX_WIDTH; x++) begin
                    main_next[x] = (ctl.live && x < SCR_W) ? scr_reg[x % SCR_W] : '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        if (ctl.scr_we) begin
            scr_reg <= scr_bus;
        end
    end

    assign row_out = main_reg;
    assign sel_pix = main_reg[sel_col];
    assign row_nz  = |main_reg;

endmodule

`default_nettype wire

>>> rtl/led_matrix_shift_rotate_trim.sv
// Top level of the LED matrix store: command sequencer and the chain of row cells.
// Depends on lmsrt_pkg and lmsrt_cell.
//
//   channel   ports            word fields (lowest bits first)
//   command   s_tvalid/tready  operation, column, row, pixel_in, size_width, size_height
//   result    m_tvalid/tready  pixel_out, width_out, height_out, status
//
// Write, read, shift, set size and refused commands pass through S_EXEC and S_DONE.
// Rotation gathers one column of the old matrix per cycle in S_ROT, then loads it in S_COPY.
// Trims remove rows or columns one at a time in S_TRIM; an empty trim goes straight to S_DONE.
// A new command is taken once the previous one has placed its result in the output
// register; a stalled result waits there while the next command runs.
// Reset clears size and handshake state; pixels are cleared by the set size command.
`default_nettype none

module led_matrix_shift_rotate_trim #(
    parameter int MAX_WIDTH  = lmsrt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lmsrt_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = lmsrt_pkg::DEF_PIXEL_BITS
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // operation[3:0], column[9:4], row[14:10], pixel_in[22:15],
    // size_width[29:23], size_height[35:30], zero pad [39:36]
    input  wire [lmsrt_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // pixel_out[7:0], width_out[14:8], height_out[20:15], status[22:21], zero [23]
    output logic [lmsrt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import lmsrt_pkg::*;

    localparam int CIW = $clog2(MAX_WIDTH);
    localparam int RIW = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int SCR_W = (MAX_WIDTH < MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DW  = 10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ROT,
        S_COPY,
        S_TRIM,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [WW-1:0]  width_reg, width_next;
    logic [HW-1:0]  height_reg, height_next;
    logic [RIW-1:0] k_reg, k_next;
    status_t        status_reg, status_next;
    logic [PIX_W-1:0] pixel_reg, pixel_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    op_t            op_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [PIX_W-1:0] pin_reg;
    logic [SZW_W-1:0] szw_reg;
    logic [SZH_W-1:0] szh_reg;

    cell_op_t       cell_op;
    logic [CIW-1:0] sel_col;
    logic           scr_on;
    logic           load_live_w;

    logic [MAX_HEIGHT-1:0][MAX_WIDTH-1:0][PIXEL_BITS-1:0] rows;
    logic [MAX_HEIGHT-1:0][PIXEL_BITS-1:0]                sel_pix;
    logic [MAX_HEIGHT-1:0]                                row_nz;
    logic [MAX_HEIGHT-1:0]                                col0_nz;
    logic [SCR_W-1:0][PIXEL_BITS-1:0]                     scr_bus;
    cell_ctl_t [MAX_HEIGHT-1:0]                           ctl;

    logic [DW-1:0] w_d, h_d, col_d, row_d, k_d;
    logic          any_nz, col0_any, sel_any, in_range, rot_left;
    logic [PIXEL_BITS-1:0] rd_pix;

    assign w_d   = DW'(width_reg);
    assign h_d   = DW'(height_reg);
    assign col_d = DW'(col_reg);
    assign row_d = DW'(row_reg);
    assign k_d   = DW'(k_reg);

    assign any_nz   = |row_nz;
    assign col0_any = |col0_nz;
    assign sel_any  = |sel_pix;
    assign in_range = (col_d < w_d) && (row_d < h_d);
    assign rd_pix   = sel_pix[RIW'(row_reg)];
    assign rot_left = (op_reg == OP_ROT_L);

    // Rotation gathers one old column into a new row; right turns reverse the order.
    always_comb begin
        for (int c = 0; c < SCR_W; c++) begin
            if (rot_left) begin
                scr_bus[c] = sel_pix[c];
            end else begin
                scr_bus[c] = (DW'(c) < h_d) ? sel_pix[RIW'(h_d - 1 - DW'(c))] : '0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_HEIGHT; i++) begin
            ctl[i].op     = cell_op;
            ctl[i].live   = load_live_w ? (DW'(i) < w_d) : (i > 0 && DW'(i) < h_d);
            ctl[i].pix_we = (RIW'(row_reg) == RIW'(i));
            ctl[i].scr_we = scr_on && (k_reg == RIW'(i));
        end
    end

    always_comb begin
        state_next    = state_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        k_next        = k_reg;
        status_next   = status_reg;
        pixel_next    = pixel_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        cell_op       = CELL_HOLD;
        sel_col       = CIW'(col_reg);
        scr_on        = 1'b0;
        load_live_w   = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next  = S_EXEC;
                    status_next = ST_OK;
                    pixel_next  = '0;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                priority if (op_reg == OP_SET_SIZE) begin
                    if (szw_reg == '0 || DW'(szw_reg) > DW'(MAX_WIDTH) ||
                        szh_reg == '0 || DW'(szh_reg) > DW'(MAX_HEIGHT)) begin
                        status_next = ST_RANGE;
                    end else begin
                        cell_op     = CELL_CLEAR;
                        width_next  = WW'(szw_reg);
                        height_next = HW'(szh_reg);
                    end
                end else if (op_reg > OP_SET_SIZE) begin
                    status_next = ST_OK;
                end else if (width_reg == '0) begin
                    status_next = ST_NOSIZE;
                end else begin
                    unique case (op_reg)
                        OP_WRITE: begin
                            if (!in_range) status_next = ST_RANGE;
                            else cell_op = CELL_WRITE;
                        end
                        OP_READ: begin
                            if (!in_range) status_next = ST_RANGE;
                            else pixel_next = PIX_W'(rd_pix);
                        end
                        OP_SHIFT_L: cell_op = CELL_SHL;
                        OP_SHIFT_R: cell_op = CELL_SHR;
                        OP_SHIFT_U: cell_op = CELL_SHU;
                        OP_SHIFT_D: cell_op = CELL_SHD;
                        OP_ROT_L, OP_ROT_R: begin
                            if (h_d > DW'(MAX_WIDTH) || w_d > DW'(MAX_HEIGHT)) begin
                                status_next = ST_EMPTY;
                            end else begin
                                k_next     = '0;
                                state_next = S_ROT;
                            end
                        end
                        OP_TRIM_L, OP_TRIM_R, OP_TRIM_T, OP_TRIM_B: begin
                            if (!any_nz) status_next = ST_EMPTY;
                            else state_next = S_TRIM;
                        end
                        default: status_next = ST_OK;
                    endcase
                end
            end
            S_ROT: begin
                scr_on  = 1'b1;
                sel_col = rot_left ? CIW'(w_d - 1 - k_d) : CIW'(k_d);
                if (k_d == w_d - 1) begin
                    state_next = S_COPY;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_COPY: begin
                cell_op     = CELL_LOAD;
                load_live_w = 1'b1;
                width_next  = WW'(h_d);
                height_next = HW'(w_d);
                state_next  = S_DONE;
            end
            S_TRIM: begin
                // The matrix is known to hold a lit pixel, so every trim stops.
                sel_col = CIW'(w_d - 1);
                unique case (op_reg)
                    OP_TRIM_L: begin
                        if (!col0_any) begin
                            cell_op    = CELL_SHL;
                            width_next = width_reg - 1'b1;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    OP_TRIM_R: begin
                        if (!sel_any) width_next = width_reg - 1'b1;
                        else state_next = S_DONE;
                    end
                    OP_TRIM_T: begin
                        if (!row_nz[0]) begin
                            cell_op     = CELL_SHU;
                            height_next = height_reg - 1'b1;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    default: begin
                        if (!row_nz[RIW'(h_d - 1)]) height_next = height_reg - 1'b1;
                        else state_next = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, status_reg, HO_W'(height_reg),
                                     WO_W'(width_reg), pixel_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            width_reg    <= '0;
            height_reg   <= '0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            k_reg        <= k_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        status_reg  <= status_next;
        pixel_reg   <= pixel_next;
        m_tdata_reg <= m_tdata_next;
        if (state_reg == S_IDLE && s_tvalid) begin
            op_reg  <= op_t'(s_tdata[3:0]);
            col_reg <= s_tdata[9:4];
            row_reg <= s_tdata[14:10];
            pin_reg <= s_tdata[22:15];
            szw_reg <= s_tdata[29:23];
            szh_reg <= s_tdata[35:30];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    for (genvar i = 0; i < MAX_HEIGHT; i++) begin : g_row
        logic [MAX_WIDTH-1:0][PIXEL_BITS-1:0] below, above;
        assign below = (i < MAX_HEIGHT - 1) ? rows[(i + 1) % MAX_HEIGHT] : '0;
        assign above = (i > 0) ? rows[(i + MAX_HEIGHT - 1) % MAX_HEIGHT] : '0;
        assign col0_nz[i] = |rows[i][0];

        lmsrt_cell #(
            .MAX_WIDTH  (MAX_WIDTH),
            .PIXEL_BITS (PIXEL_BITS),
            .SCR_W      (SCR_W)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl[i]),
            .sel_col   (sel_col),
            .wr_pix    (PIXEL_BITS'(pin_reg)),
            .width     (width_reg),
            .below_row (below),
            .above_row (above),
            .scr_bus   (scr_bus),
            .row_out   (rows[i]),
            .sel_pix   (sel_pix[i]),
            .row_nz    (row_nz[i])
        );
    end

    a_size_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (width_reg == '0) == (height_reg == '0))
        else $error("width and height disagree on being sized");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted while previous one still running");

    a_rot_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROT) |-> (k_d < w_d))
        else $error("rotation column index ran past the width");

    a_nosize_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[22:21] == ST_NOSIZE) |-> (m_tdata[14:8] == '0))
        else $error("no-size status reported with a nonzero width");

endmodule

`default_nettype wire
